/* design/hff_pkg.sv */
// ----------------------------------------------------------------------------
// hff_pkg
// Shared types, constants and helpers of the hex field formatter.
// ----------------------------------------------------------------------------
`default_nettype none

package hff_pkg;

   localparam int MAX_FIELD_DEF = 64;

   localparam int REQ_TDATA_W = 56;
   localparam int RSP_TDATA_W = 16;
   localparam int IN_CNT_W    = 7;
   localparam int CHAR_W      = 7;
   localparam int NIB_CNT_W   = 4;
   localparam int SKIP_W      = 3;

   localparam logic [CHAR_W-1:0] CH_NUL   = 7'd0;
   localparam logic [CHAR_W-1:0] CH_SPACE = 7'd32;
   localparam logic [CHAR_W-1:0] CH_ZERO  = 7'd48;
   localparam logic [CHAR_W-1:0] CH_ALPHA = 7'd55;
   localparam logic [3:0]        DEC_LIMIT = 4'd10;

   typedef struct packed {
      logic              load;
      logic              shift;
      logic [SKIP_W-1:0] skip;
   } hff_shift_ctl_type;

   function automatic logic [CHAR_W-1:0] hex_char(input logic [3:0] d);
      logic [CHAR_W-1:0] base;
      base = (d >= DEC_LIMIT) ? CH_ALPHA : CH_ZERO;
      return base + {3'b000, d};
   endfunction

endpackage

`default_nettype wire

/* design/hff_digit_shifter.sv */
// ----------------------------------------------------------------------------
// hff_digit_shifter
// Nibble shift register: holds the aligned value and gives one hex
// character per shift, most significant digit first.
// ----------------------------------------------------------------------------
`default_nettype none

module hff_digit_shifter
   import hff_pkg::*;
(
   input  wire logic              clock,
   input  wire logic [31:0]       value,
   input  wire hff_shift_ctl_type ctl,
   output logic [CHAR_W-1:0]      digit_char
);

   logic [31:0] sr_ff;
   logic [31:0] sr_in;

   always_comb begin
      sr_in = sr_ff;
      if (ctl.load) begin
         sr_in = value << {ctl.skip, 2'b00};
      end else if (ctl.shift) begin
         sr_in = {sr_ff[27:0], 4'h0};
      end
   end

   always_ff @(posedge clock) begin
      sr_ff <= sr_in;
   end

   assign digit_char = hex_char(sr_ff[31:28]);

endmodule

`default_nettype wire

/* design/hff_field_sequencer.sv */
// ----------------------------------------------------------------------------
// hff_field_sequencer
// Sizes the field and steps through space, zero and digit runs, one
// character per cycle into the result register while rsp_ready does not stall it.
// ----------------------------------------------------------------------------
`default_nettype none

module hff_field_sequencer
   import hff_pkg::*;
#(
   parameter int MAX_FIELD = MAX_FIELD_DEF,
   localparam int CNT_W    = $clog2(MAX_FIELD + 1)
) (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire logic                 req_tvalid,
   output logic                      req_tready,
   input  wire logic [31:0]          value,
   input  wire logic [IN_CNT_W-1:0]  field_width,
   input  wire logic                 has_precision,
   input  wire logic [IN_CNT_W-1:0]  min_digits,
   input  wire logic                 left_justify,
   input  wire logic                 zero_pad,
   input  wire logic [CHAR_W-1:0]    digit_char,
   output hff_shift_ctl_type         ctl,
   output logic                      rsp_valid,
   input  wire logic                 rsp_ready,
   output logic [CHAR_W-1:0]         rsp_char,
   output logic                      rsp_empty,
   output logic                      rsp_last,
   output logic [CNT_W-1:0]          rsp_count
);

   localparam logic [1:0] ST_IDLE = 2'd0;
   localparam logic [1:0] ST_PREP = 2'd1;
   localparam logic [1:0] ST_EMIT = 2'd2;

   localparam logic [IN_CNT_W-1:0] MAX_IN = IN_CNT_W'(MAX_FIELD);
   localparam logic [CNT_W-1:0]    ONE    = CNT_W'(1);

   logic [1:0]           state_ff, state_in;
   logic [CNT_W-1:0]     w_ff, w_in, p_ff, p_in;
   logic [NIB_CNT_W-1:0] nd_ff, nd_in;
   logic                 prec_ff, prec_in, left_ff, left_in, zflag_ff, zflag_in;
   logic [CNT_W-1:0]     sp_ff, sp_in, zr_ff, zr_in, rem_ff, rem_in, tot_ff, tot_in;
   logic [NIB_CNT_W-1:0] dg_ff, dg_in;
   logic                 valid_ff, valid_in;
   logic [CHAR_W-1:0]    char_ff, char_in;
   logic                 empty_ff, empty_in, last_ff, last_in;
   logic [CNT_W-1:0]     count_ff, count_in;

   logic                 accept, out_free;
   logic [NIB_CNT_W-1:0] nd_calc;
   logic [SKIP_W-1:0]    skip_calc;
   logic [CNT_W-1:0]     nd_ext, zeros_calc, body_calc, spaces_calc;

   assign req_tready = (state_ff == ST_IDLE);
   assign accept     = req_tready && req_tvalid;
   assign out_free   = !valid_ff || rsp_ready;

   always_comb begin
      nd_calc   = NIB_CNT_W'(1);
      skip_calc = SKIP_W'(7);
      for (int i = 0; i < 8; i++) begin
         if (value[4*i +: 4] != 4'h0) begin
            nd_calc   = NIB_CNT_W'(i + 1);
            skip_calc = SKIP_W'(7 - i);
         end
      end
      if (has_precision && (min_digits == '0) && (value == '0)) begin
         nd_calc = '0;
      end
   end

   always_comb begin
      nd_ext     = CNT_W'(nd_ff);
      zeros_calc = '0;
      if (prec_ff) begin
         if (p_ff > nd_ext) begin
            zeros_calc = p_ff - nd_ext;
         end
      end else if (zflag_ff && !left_ff) begin
         if (w_ff > nd_ext) begin
            zeros_calc = w_ff - nd_ext;
         end
      end
      body_calc   = nd_ext + zeros_calc;
      spaces_calc = (w_ff > body_calc) ? (w_ff - body_calc) : '0;
   end

   always_comb begin
      state_in = state_ff;
      w_in     = w_ff;
      p_in     = p_ff;
      nd_in    = nd_ff;
      prec_in  = prec_ff;
      left_in  = left_ff;
      zflag_in = zflag_ff;
      sp_in    = sp_ff;
      zr_in    = zr_ff;
      dg_in    = dg_ff;
      rem_in   = rem_ff;
      tot_in   = tot_ff;
      valid_in = valid_ff && !rsp_ready;
      char_in  = char_ff;
      empty_in = empty_ff;
      last_in  = last_ff;
      count_in = count_ff;
      ctl      = '{load: accept, shift: 1'b0, skip: skip_calc};

      unique case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               w_in     = (field_width > MAX_IN) ? CNT_W'(MAX_FIELD)
                                                 : CNT_W'(field_width);
               p_in     = (min_digits > MAX_IN) ? CNT_W'(MAX_FIELD)
                                                : CNT_W'(min_digits);
               nd_in    = nd_calc;
               prec_in  = has_precision;
               left_in  = left_justify;
               zflag_in = zero_pad;
               state_in = ST_PREP;
            end
         end
         ST_PREP: begin
            sp_in    = spaces_calc;
            zr_in    = zeros_calc;
            dg_in    = nd_ff;
            rem_in   = spaces_calc + body_calc;
            tot_in   = spaces_calc + body_calc;
            state_in = ST_EMIT;
         end
         ST_EMIT: begin
            if (out_free) begin
               valid_in = 1'b1;
               empty_in = 1'b0;
               count_in = '0;
               last_in  = 1'b0;
               if (rem_ff == '0) begin
                  char_in  = CH_NUL;
                  empty_in = 1'b1;
                  last_in  = 1'b1;
                  state_in = ST_IDLE;
               end else begin
                  rem_in = rem_ff - ONE;
                  if (!left_ff && (sp_ff != '0)) begin
                     char_in = CH_SPACE;
                     sp_in   = sp_ff - ONE;
                  end else if (zr_ff != '0) begin
                     char_in = CH_ZERO;
                     zr_in   = zr_ff - ONE;
                  end else if (dg_ff != '0) begin
                     char_in   = digit_char;
                     dg_in     = dg_ff - NIB_CNT_W'(1);
                     ctl.shift = 1'b1;
                  end else begin
                     char_in = CH_SPACE;
                     sp_in   = sp_ff - ONE;
                  end
                  if (rem_ff == ONE) begin
                     last_in  = 1'b1;
                     count_in = tot_ff;
                     state_in = ST_IDLE;
                  end
               end
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      w_ff     <= w_in;
      p_ff     <= p_in;
      nd_ff    <= nd_in;
      prec_ff  <= prec_in;
      left_ff  <= left_in;
      zflag_ff <= zflag_in;
      sp_ff    <= sp_in;
      zr_ff    <= zr_in;
      dg_ff    <= dg_in;
      rem_ff   <= rem_in;
      tot_ff   <= tot_in;
      char_ff  <= char_in;
      empty_ff <= empty_in;
      last_ff  <= last_in;
      count_ff <= count_in;
   end

   assign rsp_valid = valid_ff;
   assign rsp_char  = char_ff;
   assign rsp_empty = empty_ff;
   assign rsp_last  = last_ff;
   assign rsp_count = count_ff;

endmodule

`default_nettype wire

/* design/hex_field_formatter_unit.sv */
// ----------------------------------------------------------------------------
// hex_field_formatter_unit
// Formats a 32-bit value as a padded upper-case hex field, one character
// per output word.
// ----------------------------------------------------------------------------
//  channel   dir   handshake              payload
//  req_*     in    req_tvalid/req_tready  value, width, precision, flags
//  rsp_*     out   rsp_tvalid/rsp_tready  character, count; tuser empty; tlast
//
//  An item passes through the accept, sizing and emit states of the
//  sequencer; the emit state gives the characters one by one through the
//  single character path of the sequencer and the nibble shift register.
//  The next word is taken in the cycle after the last character is
//  registered. A stalled rsp_tready holds the sequence; reset empties the
//  result register and returns to idle.
// ----------------------------------------------------------------------------
`default_nettype none

module hex_field_formatter_unit
   import hff_pkg::*;
#(
   parameter int MAX_FIELD = MAX_FIELD_DEF
) (
   input  wire logic                   clock,
   input  wire logic                   reset,
   input  wire logic                   req_tvalid,
   output logic                        req_tready,
   // value[31:0], field_width[38:32], has_precision[39], min_digits[46:40],
   // left_justify[47], zero_pad[48], zero fill[55:49]
   input  wire logic [REQ_TDATA_W-1:0] req_tdata,
   output logic                        rsp_tvalid,
   input  wire logic                   rsp_tready,
   // character[6:0], total_count[13:7], zero fill[15:14]
   output logic [RSP_TDATA_W-1:0]      rsp_tdata,
   // empty_res[0]
   output logic                        rsp_tuser,
   output logic                        rsp_tlast
);

   localparam int CNT_W = $clog2(MAX_FIELD + 1);

   hff_shift_ctl_type ctl;
   logic [CHAR_W-1:0] digit_char;
   logic [CHAR_W-1:0] rsp_char;
   logic [CNT_W-1:0]  rsp_count;

   hff_field_sequencer #(
      .MAX_FIELD(MAX_FIELD)
   ) u_seq (
      .clock        (clock),
      .reset        (reset),
      .req_tvalid   (req_tvalid),
      .req_tready   (req_tready),
      .value        (req_tdata[31:0]),
      .field_width  (req_tdata[38:32]),
      .has_precision(req_tdata[39]),
      .min_digits   (req_tdata[46:40]),
      .left_justify (req_tdata[47]),
      .zero_pad     (req_tdata[48]),
      .digit_char   (digit_char),
      .ctl          (ctl),
      .rsp_valid    (rsp_tvalid),
      .rsp_ready    (rsp_tready),
      .rsp_char     (rsp_char),
      .rsp_empty    (rsp_tuser),
      .rsp_last     (rsp_tlast),
      .rsp_count    (rsp_count)
   );

   hff_digit_shifter u_dig (
      .clock     (clock),
      .value     (req_tdata[31:0]),
      .ctl       (ctl),
      .digit_char(digit_char)
   );

   assign rsp_tdata = {2'b00, IN_CNT_W'(rsp_count), rsp_char};

endmodule

`default_nettype wire

/* design/hff_checker.sv */
// ----------------------------------------------------------------------------
// hff_checker
// Port-level checks of the hex field formatter, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

module hff_checker
   import hff_pkg::*;
(
   input wire logic                   clock,
   input wire logic                   reset,
   input wire logic                   req_tvalid,
   input wire logic                   req_tready,
   input wire logic                   rsp_tvalid,
   input wire logic                   rsp_tready,
   input wire logic [RSP_TDATA_W-1:0] rsp_tdata,
   input wire logic                   rsp_tuser,
   input wire logic                   rsp_tlast
);

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata)
         && $stable(rsp_tlast) && $stable(rsp_tuser))
      else $error("rsp word changed while stalled");

   a_busy_after_accept: assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready |=> !req_tready)
      else $error("new word taken while field in progress");

   a_empty_shape: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tuser |-> rsp_tlast && (rsp_tdata == '0))
      else $error("empty word not last or not zero");

   a_count_last: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tuser |-> (rsp_tlast == (rsp_tdata[13:7] != 7'd0)))
      else $error("total count does not match last flag");

endmodule

bind hex_field_formatter_unit hff_checker u_hff_checker (
   .clock     (clock),
   .reset     (reset),
   .req_tvalid(req_tvalid),
   .req_tready(req_tready),
   .rsp_tvalid(rsp_tvalid),
   .rsp_tready(rsp_tready),
   .rsp_tdata (rsp_tdata),
   .rsp_tuser (rsp_tuser),
   .rsp_tlast (rsp_tlast)
);

`default_nettype wire

/* tb/hex_field_formatter_unit_test.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// hex_field_formatter_unit_test
// Streams printf-style hex requests into the formatter and checks every
// output character, the empty marker, tlast and the total count against a
// local model of the field layout. Both sides stall at random.
// ----------------------------------------------------------------------------

module hex_field_formatter_unit_test;
   import hff_pkg::*;

   localparam int FIELD_MAX   = MAX_FIELD_DEF;
   localparam int CYCLE_LIMIT = 400000;
   localparam int RANDOM_REQS = 108;

   typedef struct packed {
      logic       zero_pad;
      logic       left_justify;
      logic [6:0] min_digits;
      logic       has_precision;
      logic [6:0] field_width;
      logic [31:0] value;
   } field_req_type;

   typedef struct packed {
      logic [CHAR_W-1:0]   character;
      logic                empty_res;
      logic                last;
      logic [IN_CNT_W-1:0] total_count;
   } char_word_type;

   class field_scoreboard;
      char_word_type expected_chars[$];
      int            mismatches;
      int            fields;
      int            chars_seen;
      int            empty_fields;
      int            full_fields;

      function new();
         mismatches   = 0;
         fields       = 0;
         chars_seen   = 0;
         empty_fields = 0;
         full_fields  = 0;
      endfunction

      task report_mismatch(string what, int got, int want);
         $display("word %0d: %s got %0d want %0d", chars_seen, what, got, want);
         mismatches++;
      endtask

      function void push_char(logic [CHAR_W-1:0] ch);
         char_word_type w;
         w.character   = ch;
         w.empty_res   = 1'b0;
         w.last        = 1'b0;
         w.total_count = '0;
         expected_chars.push_back(w);
      endfunction

      // lay out spaces, zeros and digits of one field
      function void note_request(field_req_type r);
         int            width;
         int            prec;
         int            nd;
         int            zeros;
         int            spaces;
         int            total;
         logic [3:0]    d;
         char_word_type w;
         width = (r.field_width > FIELD_MAX) ? FIELD_MAX : int'(r.field_width);
         prec  = (r.min_digits > FIELD_MAX) ? FIELD_MAX : int'(r.min_digits);
         nd = 1;
         for (int i = 1; i < 8; i++)
            if ((r.value >> (4 * i)) != 0) nd = i + 1;
         if (r.has_precision && prec == 0 && r.value == 0) nd = 0;
         zeros = 0;
         if (r.has_precision) begin
            if (prec > nd) zeros = prec - nd;
         end else if (r.zero_pad && !r.left_justify && width > nd) begin
            zeros = width - nd;
         end
         spaces = (width > nd + zeros) ? width - nd - zeros : 0;
         total  = spaces + zeros + nd;
         fields++;
         if (total == FIELD_MAX) full_fields++;
         if (total == 0) begin
            w.character   = CH_NUL;
            w.empty_res   = 1'b1;
            w.last        = 1'b1;
            w.total_count = '0;
            expected_chars.push_back(w);
            empty_fields++;
            return;
         end
         if (!r.left_justify) repeat (spaces) push_char(CH_SPACE);
         repeat (zeros) push_char(CH_ZERO);
         for (int j = nd - 1; j >= 0; j--) begin
            d = r.value[4 * j +: 4];
            push_char(((d >= DEC_LIMIT) ? CH_ALPHA : CH_ZERO) + {3'b000, d});
         end
         if (r.left_justify) repeat (spaces) push_char(CH_SPACE);
         w = expected_chars.pop_back();
         w.last        = 1'b1;
         w.total_count = total[IN_CNT_W-1:0];
         expected_chars.push_back(w);
      endfunction

      task check_word(char_word_type got);
         char_word_type want;
         if (expected_chars.size() == 0) begin
            report_mismatch("unexpected word, character", got.character, -1);
            return;
         end
         want = expected_chars.pop_front();
         if (got.character != want.character)
            report_mismatch("character", got.character, want.character);
         if (got.empty_res != want.empty_res)
            report_mismatch("empty_res", got.empty_res, want.empty_res);
         if (got.last != want.last)
            report_mismatch("last", got.last, want.last);
         if (got.total_count != want.total_count)
            report_mismatch("total_count", got.total_count, want.total_count);
         if (!want.empty_res) chars_seen++;
      endtask
   endclass

   logic                   clock = 1'b0;
   logic                   reset = 1'b1;
   logic                   req_tvalid = 1'b0;
   logic                   req_tready;
   logic [REQ_TDATA_W-1:0] req_tdata = '0;
   logic                   rsp_tvalid;
   logic                   rsp_tready = 1'b0;
   logic [RSP_TDATA_W-1:0] rsp_tdata;
   logic                   rsp_tuser;
   logic                   rsp_tlast;

   bit              steady = 1'b0;
   int              cycles = 0;
   field_scoreboard sb = new();

   hex_field_formatter_unit dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .rsp_tlast  (rsp_tlast)
   );

   always begin
      clock = 1'b1;
      #10;
      clock = 1'b0;
      #10;
   end

   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles > CYCLE_LIMIT) begin
         $display("timeout after %0d cycles", cycles);
         $display("hex_field_formatter_unit: mismatch");
         $finish;
      end
   end

   always @(posedge clock) begin
      rsp_tready <= steady || ($urandom_range(99) >= 37);
   end

   always @(posedge clock) begin
      char_word_type got;
      if (!reset && rsp_tvalid && rsp_tready) begin
         got.character   = rsp_tdata[6:0];
         got.empty_res   = rsp_tuser;
         got.last        = rsp_tlast;
         got.total_count = rsp_tdata[13:7];
         sb.check_word(got);
      end
   end

   function automatic field_req_type mk_req(logic [31:0] value, logic [6:0] width,
                                            logic has_prec, logic [6:0] prec,
                                            logic left, logic zero);
      field_req_type r;
      r.value         = value;
      r.field_width   = width;
      r.has_precision = has_prec;
      r.min_digits    = prec;
      r.left_justify  = left;
      r.zero_pad      = zero;
      return r;
   endfunction

   function automatic logic [6:0] rand_size();
      int pick;
      pick = $urandom_range(9);
      if (pick < 2) return 7'd0;
      if (pick < 6) return 7'($urandom_range(12));
      if (pick < 9) return 7'($urandom_range(40));
      return 7'($urandom_range(127));
   endfunction

   function automatic field_req_type rand_req();
      logic [31:0] value;
      case ($urandom_range(4))
         0: value = 32'h0;
         1: value = 32'($urandom_range(15));
         2: value = $urandom >> (4 * $urandom_range(7));
         3: value = 32'hFFFF_FFFF >> (4 * $urandom_range(7));
         default: value = $urandom;
      endcase
      return mk_req(value, rand_size(), 1'($urandom_range(1)), rand_size(),
                    1'($urandom_range(1)), 1'($urandom_range(1)));
   endfunction

   // hold the word until accepted; leave tvalid high for the next one
   task send_request(field_req_type r);
      while (!steady && $urandom_range(99) < 37) begin
         req_tvalid <= 1'b0;
         @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= {{(REQ_TDATA_W - $bits(field_req_type)){1'b0}}, r};
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      sb.note_request(r);
   endtask

   initial begin
      repeat (10) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      send_request(mk_req(32'h0,         7'd0,   1'b0, 7'd0,   1'b0, 1'b0));
      send_request(mk_req(32'h0,         7'd0,   1'b1, 7'd0,   1'b0, 1'b0));
      send_request(mk_req(32'h0,         7'd5,   1'b1, 7'd0,   1'b0, 1'b1));
      send_request(mk_req(32'h0,         7'd5,   1'b1, 7'd0,   1'b1, 1'b0));
      send_request(mk_req(32'h0,         7'd0,   1'b1, 7'd1,   1'b0, 1'b0));
      send_request(mk_req(32'hFFFF_FFFF, 7'd0,   1'b0, 7'd0,   1'b0, 1'b0));
      send_request(mk_req(32'h0123_4567, 7'd10,  1'b0, 7'd0,   1'b0, 1'b0));
      send_request(mk_req(32'h89AB_CDEF, 7'd12,  1'b0, 7'd0,   1'b0, 1'b1));
      send_request(mk_req(32'h1234_5670, 7'd12,  1'b0, 7'd0,   1'b1, 1'b1));
      send_request(mk_req(32'h0000_000A, 7'd10,  1'b1, 7'd4,   1'b0, 1'b1));
      send_request(mk_req(32'h0000_BEEF, 7'd10,  1'b1, 7'd6,   1'b1, 1'b1));
      send_request(mk_req(32'h0001_2345, 7'd3,   1'b1, 7'd3,   1'b0, 1'b0));
      send_request(mk_req(32'h0000_0010, 7'd2,   1'b1, 7'd0,   1'b0, 1'b0));
      send_request(mk_req(32'h0000_000D, 7'd1,   1'b0, 7'd0,   1'b1, 1'b0));
      send_request(mk_req(32'h0000_0005, 7'd127, 1'b0, 7'd0,   1'b0, 1'b0));
      send_request(mk_req(32'h0000_000C, 7'd0,   1'b1, 7'd127, 1'b0, 1'b0));
      send_request(mk_req(32'h0000_0F00, 7'd127, 1'b1, 7'd100, 1'b1, 1'b1));
      send_request(mk_req(32'hFFFF_FFFF, 7'd64,  1'b0, 7'd0,   1'b0, 1'b1));
      send_request(mk_req(32'h8000_0001, 7'd65,  1'b0, 7'd0,   1'b0, 1'b1));
      send_request(mk_req(32'hFFFF_FFFF, 7'd0,   1'b1, 7'd64,  1'b0, 1'b0));
      send_request(mk_req(32'h0000_0000, 7'd127, 1'b1, 7'd0,   1'b1, 1'b1));
      send_request(mk_req(32'h0000_0000, 7'd8,   1'b0, 7'd0,   1'b0, 1'b1));

      for (int n = 0; n < RANDOM_REQS; n++) begin
         steady = (n >= 50 && n < 85);
         send_request(rand_req());
      end
      steady = 1'b0;
      req_tvalid <= 1'b0;

      while (sb.expected_chars.size() != 0) @(posedge clock);
      repeat (FIELD_MAX + 8) @(posedge clock);

      $display("covered %0d fields, %0d characters, %0d empty fields, %0d at full width",
               sb.fields, sb.chars_seen, sb.empty_fields, sb.full_fields);
      $display("finished in %0d cycles with %0d mismatches", cycles, sb.mismatches);
      if (sb.mismatches == 0)
         $display("hex_field_formatter_unit: match");
      else
         $display("hex_field_formatter_unit: mismatch");
      $finish;
   end

endmodule

/* files.f */
design/hff_pkg.sv
design/hff_digit_shifter.sv
design/hff_field_sequencer.sv
design/hex_field_formatter_unit.sv
design/hff_checker.sv
tb/hex_field_formatter_unit_test.sv
